/* rtl/cvp_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cvp_pkg
// Shared types, constants and the quarter-wave sine table of the camera
// vertex projection core.
// ---------------------------------------------------------------------------
package cvp_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int ANGLE_STEPS   = 1024;
   localparam int ANGLE_BITS    = $clog2(ANGLE_STEPS);
   localparam int QUARTER_STEPS = ANGLE_STEPS / 4;
   localparam int QBITS         = ANGLE_BITS - 2;
   localparam int DIV_STEPS     = 63;
   localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CAMERA_X    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAMERA_Y    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAMERA_Z    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_X    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_Y    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEAR_PLANE  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_DEPTH  = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VIEW_ANGLES = 3'd7;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int SIN_DIVS [5] = '{110, 72, 42, 20, 6};

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
      logic [1:0]         corner;
   } req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic               point_visible;
      logic               screen_visible;
      logic               quad_visible;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] camera_x;
      logic signed [31:0] camera_y;
      logic signed [31:0] camera_z;
      logic [30:0]        center_x;
      logic [30:0]        center_y;
      logic signed [31:0] near_plane;
      logic signed [31:0] clip_depth;
      logic [19:0]        view_angles;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL,
      OP_ACC,
      OP_FIN,
      OP_PMUL,
      OP_DSTART,
      OP_DITER,
      OP_DFIN,
      OP_OUT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [2:0] term;
      logic       axis;
   } cmd_type;

   typedef logic [30:0] sin_tab_type [QUARTER_STEPS];

   function automatic logic [30:0] sin_quarter(input int unsigned idx);
      logic [63:0] f;
      logic [63:0] r;
      logic [63:0] r2;
      logic [63:0] t;
      logic [63:0] s;
      f  = (64'(idx) << 32) / QUARTER_STEPS;
      r  = (f * HALF_PI_Q30) >> 32;
      r2 = (r * r) >> 30;
      t  = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
         t = Q30_ONE - (((r2 * t) >> 30) / 64'(SIN_DIVS[i]));
      end
      s = (r * t) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      return 31'(s);
   endfunction

   function automatic sin_tab_type build_sin_tab();
      sin_tab_type tab;
      for (int i = 0; i < QUARTER_STEPS; i++) begin
         tab[i] = sin_quarter(i);
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TAB  = build_sin_tab();
   localparam logic [30:0] SIN_PEAK = sin_quarter(QUARTER_STEPS);

endpackage
`default_nettype wire

/* rtl/cvp_csr.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cvp_csr
// Configuration registers, written through a plain write port.
// ---------------------------------------------------------------------------
module cvp_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [cvp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [31:0]                        csr_wdata,
   output cvp_pkg::cfg_type                        cfg
);

   cvp_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_x    <= '0;
         cfg_ff.camera_y    <= '0;
         cfg_ff.camera_z    <= '0;
         cfg_ff.center_x    <= 31'(320 << cvp_pkg::FRAC_BITS);
         cfg_ff.center_y    <= 31'(240 << cvp_pkg::FRAC_BITS);
         cfg_ff.near_plane  <= 32'(256 << cvp_pkg::FRAC_BITS);
         cfg_ff.clip_depth  <= 32'(32 << cvp_pkg::FRAC_BITS);
         cfg_ff.view_angles <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            cvp_pkg::CSR_CAMERA_X:    cfg_ff.camera_x    <= csr_wdata;
            cvp_pkg::CSR_CAMERA_Y:    cfg_ff.camera_y    <= csr_wdata;
            cvp_pkg::CSR_CAMERA_Z:    cfg_ff.camera_z    <= csr_wdata;
            cvp_pkg::CSR_CENTER_X:    cfg_ff.center_x    <= csr_wdata[30:0];
            cvp_pkg::CSR_CENTER_Y:    cfg_ff.center_y    <= csr_wdata[30:0];
            cvp_pkg::CSR_NEAR_PLANE:  cfg_ff.near_plane  <= csr_wdata;
            cvp_pkg::CSR_CLIP_DEPTH:  cfg_ff.clip_depth  <= csr_wdata;
            cvp_pkg::CSR_VIEW_ANGLES: cfg_ff.view_angles <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/cvp_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cvp_ctrl
// Sequencer: steps the datapath through translation, rotation, the two
// projection divisions and the output load, and owns the handshakes.
// ---------------------------------------------------------------------------
module cvp_ctrl (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output cvp_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_FIN,
      ST_PMUL,
      ST_DSTART,
      ST_DITER,
      ST_DFIN,
      ST_OUT
   } state_type;

   state_type                          state_ff;
   logic [2:0]                         term_ff;
   logic                               axis_ff;
   logic [cvp_pkg::DIV_CNT_BITS-1:0]   cnt_ff;
   logic                               rsp_valid_ff;
   logic                               out_ready;

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= '0;
         axis_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  term_ff  <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: state_ff <= ST_ACC;
            ST_ACC: begin
               if (term_ff[0]) begin
                  state_ff <= ST_FIN;
               end else begin
                  term_ff  <= term_ff + 3'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_FIN: begin
               if (term_ff == 3'd7) begin
                  axis_ff  <= 1'b0;
                  state_ff <= ST_PMUL;
               end else begin
                  term_ff  <= term_ff + 3'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_PMUL: state_ff <= ST_DSTART;
            ST_DSTART: begin
               cnt_ff   <= '0;
               state_ff <= ST_DITER;
            end
            ST_DITER: begin
               if (cnt_ff == cvp_pkg::DIV_CNT_BITS'(cvp_pkg::DIV_STEPS - 1)) begin
                  state_ff <= ST_DFIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DFIN: begin
               if (axis_ff) begin
                  state_ff <= ST_OUT;
               end else begin
                  axis_ff  <= 1'b1;
                  state_ff <= ST_PMUL;
               end
            end
            ST_OUT: begin
               if (out_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.term = term_ff;
      cmd.axis = axis_ff;
      unique case (state_ff)
         ST_IDLE:   cmd.op = req_valid ? cvp_pkg::OP_LOAD : cvp_pkg::OP_NONE;
         ST_MUL:    cmd.op = cvp_pkg::OP_MUL;
         ST_ACC:    cmd.op = cvp_pkg::OP_ACC;
         ST_FIN:    cmd.op = cvp_pkg::OP_FIN;
         ST_PMUL:   cmd.op = cvp_pkg::OP_PMUL;
         ST_DSTART: cmd.op = cvp_pkg::OP_DSTART;
         ST_DITER:  cmd.op = cvp_pkg::OP_DITER;
         ST_DFIN:   cmd.op = cvp_pkg::OP_DFIN;
         ST_OUT:    cmd.op = out_ready ? cvp_pkg::OP_OUT : cvp_pkg::OP_NONE;
         default:   cmd.op = cvp_pkg::OP_NONE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("Result raised outside the output state.");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DITER) |-> (cnt_ff < cvp_pkg::DIV_CNT_BITS'(cvp_pkg::DIV_STEPS)))
      else $error("Divider step count out of range.");

   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_OUT))
      else $error("Output overwritten while stalled.");

endmodule
`default_nettype wire

/* rtl/cvp_datapath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cvp_datapath
// Translation, trig lookup, shared 32x32 multiplier with accumulator,
// radix-2 restoring divider, visibility flags and the quad corner counter.
// ---------------------------------------------------------------------------
module cvp_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cvp_pkg::cmd_type  cmd,
   input  wire cvp_pkg::cfg_type  cfg,
   input  wire cvp_pkg::req_type  req_payload,
   output cvp_pkg::rsp_type       rsp_payload
);

   localparam int AB = cvp_pkg::ANGLE_BITS;
   localparam int QB = cvp_pkg::QBITS;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] trig(input logic [AB-1:0] a);
      logic [1:0]  quad;
      logic [QB-1:0] low;
      logic [31:0] m;
      quad = a[AB-1 -: 2];
      low  = a[QB-1:0];
      if (quad[0] && (low == '0)) begin
         m = {1'b0, cvp_pkg::SIN_PEAK};
      end else if (quad[0]) begin
         m = {1'b0, cvp_pkg::SIN_TAB[QB'(~low + QB'(1))]};
      end else begin
         m = {1'b0, cvp_pkg::SIN_TAB[low]};
      end
      return quad[1] ? -m : m;
   endfunction

   logic signed [31:0] x_ff, y_ff, z_ff, t_ff;
   logic signed [31:0] sy_ff, cy_ff, sp_ff, cp_ff;
   logic [1:0]         corner_ff;
   logic signed [63:0] prod_ff, acc_ff;
   logic [62:0]        num_ff;
   logic [30:0]        rem_ff, div_ff;
   logic               neg_ff;
   logic signed [31:0] sx_ff, sy_scr_ff;
   logic               inx_ff, iny_ff;
   logic [2:0]         count_ff;
   cvp_pkg::rsp_type   rsp_ff;

   logic signed [33:0] tx, ty, tz;
   logic [AB-1:0]      yaw, pitch;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic signed [63:0] fin_v;
   logic signed [63:0] mag;
   logic [31:0]        rem_sh;
   logic               q_bit;
   logic [30:0]        rem_in;
   logic signed [63:0] qv, pv;
   logic signed [31:0] ctr;
   logic               pvis, svis, hit;
   logic [2:0]         count_in;

   assign tx = 34'(req_payload.vertex_x) - 34'(cfg.camera_x)
             - $signed({3'b000, cfg.center_x});
   assign ty = 34'(req_payload.vertex_y) - 34'(cfg.camera_y)
             - $signed({3'b000, cfg.center_y});
   assign tz = 34'(req_payload.vertex_z) - 34'(cfg.camera_z) + 34'(cfg.near_plane);

   assign yaw   = cfg.view_angles[AB-1:0];
   assign pitch = cfg.view_angles[10 +: AB];

   always_comb begin
      if (cmd.op == cvp_pkg::OP_PMUL) begin
         mul_a = cmd.axis ? y_ff : x_ff;
         mul_b = cfg.near_plane;
      end else begin
         case (cmd.term)
            3'd0:    begin mul_a = x_ff; mul_b = cy_ff; end
            3'd1:    begin mul_a = z_ff; mul_b = sy_ff; end
            3'd2:    begin mul_a = x_ff; mul_b = sy_ff; end
            3'd3:    begin mul_a = z_ff; mul_b = cy_ff; end
            3'd4:    begin mul_a = y_ff; mul_b = sp_ff; end
            3'd5:    begin mul_a = z_ff; mul_b = cp_ff; end
            3'd6:    begin mul_a = y_ff; mul_b = cp_ff; end
            default: begin mul_a = z_ff; mul_b = sp_ff; end
         endcase
      end
   end

   assign mul_p = mul_a * mul_b;
   assign fin_v = (acc_ff + 64'sd536870912) >>> 30;
   assign mag   = prod_ff[63] ? -prod_ff : prod_ff;

   assign rem_sh = {rem_ff, num_ff[62]};
   assign q_bit  = (rem_sh >= {1'b0, div_ff});
   assign rem_in = q_bit ? 31'(rem_sh - {1'b0, div_ff}) : rem_sh[30:0];

   assign qv  = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});
   assign ctr = cmd.axis ? $signed({1'b0, cfg.center_y}) : $signed({1'b0, cfg.center_x});
   assign pv  = qv + 64'(ctr);

   assign pvis     = (z_ff >= cfg.clip_depth);
   assign svis     = (z_ff > 0) ? (inx_ff && iny_ff) : pvis;
   assign hit      = pvis && svis;
   always_comb begin
      count_in = (corner_ff == 2'd0) ? 3'd0 : count_ff;
      if (hit && (count_in != 3'd7)) begin
         count_in = count_in + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         cvp_pkg::OP_LOAD: begin
            x_ff      <= sat32(64'(tx));
            y_ff      <= sat32(64'(ty));
            z_ff      <= sat32(64'(tz));
            corner_ff <= req_payload.corner;
            sy_ff     <= trig(yaw);
            cy_ff     <= trig(yaw + AB'(cvp_pkg::QUARTER_STEPS));
            sp_ff     <= trig(pitch);
            cp_ff     <= trig(pitch + AB'(cvp_pkg::QUARTER_STEPS));
         end
         cvp_pkg::OP_MUL, cvp_pkg::OP_PMUL: prod_ff <= mul_p;
         cvp_pkg::OP_ACC: begin
            case (cmd.term)
               3'd2:    acc_ff <= -prod_ff;
               3'd7:    acc_ff <= acc_ff - prod_ff;
               default: acc_ff <= cmd.term[0] ? acc_ff + prod_ff : prod_ff;
            endcase
         end
         cvp_pkg::OP_FIN: begin
            case (cmd.term)
               3'd3: begin
                  x_ff <= t_ff;
                  z_ff <= sat32(fin_v);
               end
               3'd7: begin
                  y_ff <= sat32(fin_v);
                  z_ff <= t_ff;
               end
               default: t_ff <= sat32(fin_v);
            endcase
         end
         cvp_pkg::OP_DSTART: begin
            neg_ff <= prod_ff[63];
            num_ff <= mag[62:0];
            rem_ff <= '0;
            div_ff <= (z_ff > 0) ? z_ff[30:0] : 31'(1 << cvp_pkg::FRAC_BITS);
         end
         cvp_pkg::OP_DITER: begin
            rem_ff <= rem_in;
            num_ff <= {num_ff[61:0], q_bit};
         end
         cvp_pkg::OP_DFIN: begin
            if (cmd.axis) begin
               sy_scr_ff <= sat32(pv);
               iny_ff    <= (pv >= 0) && (pv < 64'({ctr, 1'b0}));
            end else begin
               sx_ff  <= sat32(pv);
               inx_ff <= (pv >= 0) && (pv < 64'({ctr, 1'b0}));
            end
         end
         cvp_pkg::OP_OUT: begin
            rsp_ff.screen_x       <= sx_ff;
            rsp_ff.screen_y       <= sy_scr_ff;
            rsp_ff.point_visible  <= pvis;
            rsp_ff.screen_visible <= svis;
            rsp_ff.quad_visible   <= (corner_ff == 2'd3) && (count_in > 3'd1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.op == cvp_pkg::OP_OUT) begin
         count_ff <= count_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

/* rtl/camera_vertex_projection_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// camera_vertex_projection_core
// Translates, rotates and perspective-projects one Q16.16 vertex per
// transaction and flags point, screen and quad visibility.
//
//   Channel   Direction  Ports                              Transaction
//   req       in         req_valid req_stall req_payload    valid && !stall
//   rsp       out        rsp_valid rsp_stall rsp_payload    valid && !stall
//   csr       in         csr_we csr_index csr_wdata         csr_we
//
// One vertex passes from acceptance through the shared multiplier and
// accumulator for the two rotations, two projections set by the 63-step
// radix-2 divider and the output state that loads the result. The next
// vertex is accepted only once the controller is back in its idle state.
// Reset is synchronous and restores the register defaults and the corner count.
// A result waits in the output register under rsp_stall while the next
// vertex is already in work.
// ---------------------------------------------------------------------------
module camera_vertex_projection_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire cvp_pkg::req_type                   req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output cvp_pkg::rsp_type                        rsp_payload,
   input  wire logic                               csr_we,
   input  wire logic [cvp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [31:0]                        csr_wdata
);

   cvp_pkg::cfg_type cfg;
   cvp_pkg::cmd_type cmd;

   cvp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cvp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
